### hdl/sorted_edge_membership_table_defines.svh
// Assertion macros for the sorted edge membership table RTL.
`ifndef SORTED_EDGE_MEMBERSHIP_TABLE_DEFINES_SVH
`define SORTED_EDGE_MEMBERSHIP_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SETM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SETM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/setm_pkg.sv
// Package of types and constants for the sorted edge membership table.
`default_nettype none
package setm_pkg;

    localparam int MAX_EDGES_DEF = 1024;
    localparam int NODE_BITS_DEF = 16;

    localparam int NODE_IN_W     = 16;
    localparam int KIND_W        = 2;
    localparam int ENTRY_COUNT_W = 11;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_SHIFT,
        ST_SHIFT_LAST,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                     found;
        logic                     status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } res_t;

endpackage
`default_nettype wire

### hdl/setm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module setm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### hdl/setm_key.sv
// Masks both node numbers and packs them as a search key, smaller node first.
`default_nettype none
module setm_key #(
    parameter int NODE_BITS = setm_pkg::NODE_BITS_DEF
) (
    input  wire logic [setm_pkg::NODE_IN_W-1:0] node_a,
    input  wire logic [setm_pkg::NODE_IN_W-1:0] node_b,
    output logic      [2*NODE_BITS-1:0]         key
);

    logic [NODE_BITS+setm_pkg::NODE_IN_W-1:0] a_ext;
    logic [NODE_BITS+setm_pkg::NODE_IN_W-1:0] b_ext;
    logic [NODE_BITS-1:0]                     a_m;
    logic [NODE_BITS-1:0]                     b_m;

    // Zero-extend first so that the select works for node widths both below
    // and above the port width.
    assign a_ext = {{NODE_BITS{1'b0}}, node_a};
    assign b_ext = {{NODE_BITS{1'b0}}, node_b};
    assign a_m   = a_ext[NODE_BITS-1:0];
    assign b_m   = b_ext[NODE_BITS-1:0];

    assign key = (a_m < b_m) ? {a_m, b_m} : {b_m, a_m};

endmodule
`default_nettype wire

### hdl/setm_engine.sv
// Search and insertion sequencer working on the sorted edge memory.
`default_nettype none
`include "sorted_edge_membership_table_defines.svh"
module setm_engine #(
    parameter int MAX_EDGES = setm_pkg::MAX_EDGES_DEF,
    parameter int NODE_BITS = setm_pkg::NODE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [setm_pkg::KIND_W-1:0]       kind,
    input  wire logic [2*NODE_BITS-1:0]            key,
    output logic                                   done,
    input  wire logic                              out_free,
    output setm_pkg::res_t                         res,
    output logic                                   ram_wr_en,
    output logic      [$clog2(MAX_EDGES)-1:0]      ram_wr_addr,
    output logic      [2*NODE_BITS-1:0]            ram_wr_data,
    output logic                                   ram_rd_en,
    output logic      [$clog2(MAX_EDGES)-1:0]      ram_rd_addr,
    input  wire logic [2*NODE_BITS-1:0]            ram_rd_data
);

    localparam int AW    = $clog2(MAX_EDGES);
    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int KEY_W = 2 * NODE_BITS;
    localparam int EC_W  = setm_pkg::ENTRY_COUNT_W;

    setm_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]           cnt_reg;
    logic                       pend_reg;
    logic [KEY_W-1:0]           key_reg;
    logic [setm_pkg::KIND_W-1:0] kind_reg;
    logic [CNT_W-1:0]           lo_reg;
    logic [CNT_W-1:0]           hi_reg;
    logic [AW-1:0]              mid_reg;
    logic                       eq_reg;
    logic [AW-1:0]              sh_reg;
    logic [AW-1:0]              pend_addr_reg;
    logic                       found_reg;
    logic                       status_reg;

    logic [CNT_W-1:0]      mid;
    logic                  accept;
    logic                  full;
    logic                  searching;
    logic                  shift_last;
    logic [CNT_W+EC_W-1:0] cnt_ext;

    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign accept     = (state_reg == setm_pkg::ST_IDLE) && s_valid;
    assign full       = (cnt_reg == CNT_W'(MAX_EDGES));
    assign searching  = (lo_reg < hi_reg);
    assign shift_last = (CNT_W'(sh_reg) == lo_reg);
    assign cnt_ext    = {{EC_W{1'b0}}, cnt_reg};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            setm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (kind)
                        setm_pkg::KIND_INSERT:
                            state_next = full ? setm_pkg::ST_DONE : setm_pkg::ST_SEARCH_RD;
                        setm_pkg::KIND_QUERY: state_next = setm_pkg::ST_SEARCH_RD;
                        default:              state_next = setm_pkg::ST_DONE;
                    endcase
                end
            end
            setm_pkg::ST_SEARCH_RD: begin
                priority if (searching) begin
                    state_next = setm_pkg::ST_SEARCH_CMP;
                end else if (kind_reg == setm_pkg::KIND_QUERY) begin
                    state_next = setm_pkg::ST_DONE;
                end else if (lo_reg < cnt_reg) begin
                    state_next = setm_pkg::ST_SHIFT;
                end else begin
                    state_next = setm_pkg::ST_WRITE;
                end
            end
            setm_pkg::ST_SEARCH_CMP: state_next = setm_pkg::ST_SEARCH_RD;
            setm_pkg::ST_SHIFT: begin
                if (shift_last) begin
                    state_next = setm_pkg::ST_SHIFT_LAST;
                end
            end
            setm_pkg::ST_SHIFT_LAST: state_next = setm_pkg::ST_WRITE;
            setm_pkg::ST_WRITE:      state_next = setm_pkg::ST_DONE;
            setm_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = setm_pkg::ST_IDLE;
                end
            end
            default: state_next = setm_pkg::ST_IDLE;
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        s_ready     = 1'b0;
        done        = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = mid[AW-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = pend_addr_reg + AW'(1);
        ram_wr_data = ram_rd_data;
        unique case (state_reg)
            setm_pkg::ST_IDLE:      s_ready = 1'b1;
            setm_pkg::ST_SEARCH_RD: ram_rd_en = searching;
            setm_pkg::ST_SEARCH_CMP: ;
            setm_pkg::ST_SHIFT: begin
                // Reads walk downwards while each entry is written one place up,
                // so the write always lands two above the address being read.
                ram_rd_en   = 1'b1;
                ram_rd_addr = sh_reg;
                ram_wr_en   = pend_reg;
            end
            setm_pkg::ST_SHIFT_LAST: ram_wr_en = 1'b1;
            setm_pkg::ST_WRITE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = lo_reg[AW-1:0];
                ram_wr_data = key_reg;
            end
            setm_pkg::ST_DONE: done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= setm_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && (kind == setm_pkg::KIND_CLEAR)) begin
                cnt_reg <= '0;
            end else if (state_reg == setm_pkg::ST_WRITE) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (state_reg == setm_pkg::ST_IDLE) begin
                pend_reg <= 1'b0;
            end else if (state_reg == setm_pkg::ST_SHIFT) begin
                pend_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg    <= key;
            kind_reg   <= kind;
            lo_reg     <= '0;
            hi_reg     <= cnt_reg;
            eq_reg     <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= (kind == setm_pkg::KIND_INSERT) && full;
        end
        if (state_reg == setm_pkg::ST_SEARCH_RD) begin
            mid_reg <= mid[AW-1:0];
            sh_reg  <= AW'(cnt_reg - CNT_W'(1));
            // The last entry found not above the key sits just below lo, so its
            // equality flag decides membership.
            if (!searching && (kind_reg == setm_pkg::KIND_QUERY)) begin
                found_reg <= (lo_reg != '0) && eq_reg;
            end
        end
        if (state_reg == setm_pkg::ST_SEARCH_CMP) begin
            if (ram_rd_data <= key_reg) begin
                lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
                eq_reg <= (ram_rd_data == key_reg);
            end else begin
                hi_reg <= CNT_W'(mid_reg);
            end
        end
        if (state_reg == setm_pkg::ST_SHIFT) begin
            pend_addr_reg <= sh_reg;
            if (!shift_last) begin
                sh_reg <= sh_reg - AW'(1);
            end
        end
    end

    assign res.found       = found_reg;
    assign res.status      = status_reg;
    assign res.entry_count = cnt_ext[EC_W-1:0];

    `SETM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_EDGES), "entry count above table depth")
    `SETM_ASSERT_NOW(a_no_rw_clash, aclk, aresetn, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "read and write hit the same entry")
    `SETM_ASSERT_NOW(a_search_window, aclk, aresetn, (state_reg == setm_pkg::ST_SEARCH_RD) || (state_reg == setm_pkg::ST_SEARCH_CMP), hi_reg <= cnt_reg, "search window beyond table fill")
    `SETM_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != setm_pkg::ST_IDLE, "item accepted but sequencer stayed idle")
    `SETM_ASSERT_NOW(a_insert_room, aclk, aresetn, state_reg == setm_pkg::ST_WRITE, cnt_reg < CNT_W'(MAX_EDGES), "insert write into a full table")

endmodule
`default_nettype wire

### hdl/sorted_edge_membership_table.sv
// Top level of the sorted edge membership table with its result register.
// Edges are held normalised (smaller node first) in ascending order in one
// MAX_EDGES-deep memory with a registered read. Every item gives one result.
// A clear, an unused kind or an insert into a full table goes straight to the
// hand-over of its result. A query runs a binary search, each step an address
// out and then a compare on the returned word, then closes the search and hands
// the result over. An insert runs the same search and then moves every entry
// above its place up by one through the single write port, one entry per cycle,
// before writing the new edge. A result still held on m_valid delays the
// hand-over until m_ready. Duplicates are kept, after equal entries. The next
// item is taken while a result waits on m_valid.
`default_nettype none
module sorted_edge_membership_table #(
    parameter int MAX_EDGES = setm_pkg::MAX_EDGES_DEF,
    parameter int NODE_BITS = setm_pkg::NODE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [setm_pkg::KIND_W-1:0]           s_kind,
    input  wire logic [setm_pkg::NODE_IN_W-1:0]        s_node_a,
    input  wire logic [setm_pkg::NODE_IN_W-1:0]        s_node_b,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_found,
    output logic                                       m_status,
    output logic      [setm_pkg::ENTRY_COUNT_W-1:0]    m_entry_count
);

    localparam int AW    = $clog2(MAX_EDGES);
    localparam int KEY_W = 2 * NODE_BITS;

    logic [KEY_W-1:0] key;
    logic             done;
    logic             out_free;
    setm_pkg::res_t   res;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [KEY_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [KEY_W-1:0] ram_rd_data;

    logic                                 m_valid_reg;
    logic                                 m_found_reg;
    logic                                 m_status_reg;
    logic [setm_pkg::ENTRY_COUNT_W-1:0]   m_entry_count_reg;

    setm_key #(
        .NODE_BITS (NODE_BITS)
    ) u_key (
        .node_a (s_node_a),
        .node_b (s_node_b),
        .key    (key)
    );

    setm_engine #(
        .MAX_EDGES (MAX_EDGES),
        .NODE_BITS (NODE_BITS)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .kind        (s_kind),
        .key         (key),
        .done        (done),
        .out_free    (out_free),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    setm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The result register is free when empty or being emptied this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done && out_free) begin
            m_found_reg       <= res.found;
            m_status_reg      <= res.status;
            m_entry_count_reg <= res.entry_count;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule
`default_nettype wire
